@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bkv_pkg.sv @@
// ----------------------------------------------------------------------------
// bkv_pkg
// Types, sizes and operation codes of the bounded key/value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bkv_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int OP_W    = 3;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE    = 3'd1;
  localparam logic [OP_W-1:0] OP_UPSERT    = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE     = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_AT   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] req_key;
    logic [DATA_W-1:0] req_value;
    logic [IDX_W-1:0]  req_index;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  out_key;
    logic [DATA_W-1:0]  out_value;
    logic [ENTRY_W-1:0] entry_count;
    logic               is_empty;
  } rsp_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } pair_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pair_t             wr_data;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/bkv_pair_ram.sv @@
// ----------------------------------------------------------------------------
// bkv_pair_ram
// Key/value pair storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkv_pair_ram (
  input  logic               clk,
  input  bkv_pkg::ram_req_t  ram_req,
  output bkv_pkg::pair_t     rdata
);
  import bkv_pkg::*;

  pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_req.rd_en) begin
      rdata <= mem[ram_req.rd_addr];
    end
  end

endmodule

@@ rtl/bkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// bkv_ctrl
// Request sequencer: scans the pair memory for a key, writes back updates,
// appends inserts, compacts the table on erase and reads a pair by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkv_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  bkv_pkg::req_t               req,
  input  logic [bkv_pkg::CAP_W-1:0]   capacity,
  output bkv_pkg::ram_req_t           ram_req,
  input  bkv_pkg::pair_t              ram_rdata,
  output logic                        res_valid,
  input  logic                        res_taken,
  output bkv_pkg::rsp_t               res
);
  import bkv_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [OP_W-1:0]        op;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] val;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       scan_idx;
  logic [CNT_W-1:0]       scan_idx_next;
  logic                   pend;
  logic                   pend_next;
  logic [ADDR_W-1:0]      pend_idx;
  logic [ADDR_W-1:0]      pend_idx_next;
  rsp_t                   res_next;

  logic accept;
  logic hit;
  logic scan_end;
  logic full;
  logic idx_ok;
  logic erase_more;

  assign accept     = req_valid && (state == ST_IDLE);
  assign req_stall  = (state != ST_IDLE);
  assign res_valid  = (state == ST_DONE);
  assign hit        = pend && (ram_rdata.key == key);
  assign scan_end   = (scan_idx >= count);
  assign full       = (count >= CNT_W'(capacity)) || (count >= CNT_W'(DEPTH));
  assign idx_ok     = (CNT_W'(req.req_index) < count);
  assign erase_more = ((CNT_W'(pend_idx) + CNT_W'(1)) < count);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.opcode == OP_READ_AT) begin
            state_next = idx_ok ? ST_READ : ST_DONE;
          end else if (req.opcode == OP_INSERT || req.opcode == OP_UPDATE ||
                       req.opcode == OP_UPSERT || req.opcode == OP_ERASE ||
                       req.opcode == OP_LOOKUP) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = (op == OP_ERASE && erase_more) ? ST_SHIFT : ST_DONE;
        end else if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_SHIFT: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_req       = '0;
    count_next    = count;
    scan_idx_next = scan_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    res_next      = res;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ram_req.rd_en      = 1'b1;
          ram_req.rd_addr    = ADDR_W'(req.req_index);
          scan_idx_next      = '0;
          pend_next          = 1'b0;
          res_next.ok        = 1'b0;
          res_next.out_key   = '0;
          res_next.out_value = '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          case (op)
            OP_UPDATE, OP_UPSERT: begin
              ram_req.wr_en         = 1'b1;
              ram_req.wr_addr       = pend_idx;
              ram_req.wr_data.key   = key;
              ram_req.wr_data.value = val;
              res_next.ok           = 1'b1;
            end
            OP_ERASE: begin
              if (erase_more) begin
                scan_idx_next = CNT_W'(pend_idx) + CNT_W'(1);
              end else begin
                count_next  = count - CNT_W'(1);
                res_next.ok = 1'b1;
              end
            end
            OP_LOOKUP: begin
              res_next.ok        = 1'b1;
              res_next.out_value = DATA_W'(ram_rdata.value);
            end
            default: begin
              res_next.ok = 1'b0;
            end
          endcase
        end else if (scan_end) begin
          if ((op == OP_INSERT || op == OP_UPSERT) && !full) begin
            ram_req.wr_en         = 1'b1;
            ram_req.wr_addr       = ADDR_W'(count);
            ram_req.wr_data.key   = key;
            ram_req.wr_data.value = val;
            count_next            = count + CNT_W'(1);
            res_next.ok           = 1'b1;
          end
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = ADDR_W'(scan_idx);
          pend_next       = 1'b1;
          pend_idx_next   = ADDR_W'(scan_idx);
          scan_idx_next   = scan_idx + CNT_W'(1);
        end
      end
      ST_READ: begin
        res_next.ok        = 1'b1;
        res_next.out_key   = DATA_W'(ram_rdata.key);
        res_next.out_value = DATA_W'(ram_rdata.value);
      end
      ST_SHIFT: begin
        if (pend) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = pend_idx - ADDR_W'(1);
          ram_req.wr_data = ram_rdata;
        end
        if (!scan_end) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = ADDR_W'(scan_idx);
          pend_next       = 1'b1;
          pend_idx_next   = ADDR_W'(scan_idx);
          scan_idx_next   = scan_idx + CNT_W'(1);
        end else begin
          pend_next   = 1'b0;
          count_next  = count - CNT_W'(1);
          res_next.ok = 1'b1;
        end
      end
      ST_DONE: begin
        res_next = res;
      end
      default: begin
        pend_next = 1'b0;
      end
    endcase
    if (state != ST_DONE) begin
      res_next.entry_count = ENTRY_W'(count_next);
      res_next.is_empty    = (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.opcode;
      key <= KEY_WIDTH'(req.req_key);
      val <= VALUE_WIDTH'(req.req_value);
    end
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    res      <= res_next;
  end

endmodule

@@ rtl/bounded_key_value_table.sv @@
// ----------------------------------------------------------------------------
// bounded_key_value_table
// Key/value table of bounded capacity held in a single pair memory.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives exactly one response. An
// undefined opcode or a read at an index not below the count goes straight
// to the response; a read at a valid index first reads the pair memory. A
// key search reads the stored pairs in order until it hits the key or
// reaches the count. An erase that hits moves each later pair down by one
// place. The response shows in the same cycle in which the next request
// can first be taken. The search and the compaction are paced by the
// single read port of the pair memory, which visits one entry per cycle.
// A new request is taken while the previous response still waits in the
// output register. Capacity may be written only while no request is in
// flight.
`timescale 1ns / 1ps

module bounded_key_value_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bkv_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bkv_pkg::rsp_t              rsp,
  input  logic                       cfg_wr_en,
  input  logic [bkv_pkg::CAP_W-1:0]  cfg_wr_data
);
  import bkv_pkg::*;

  logic [CAP_W-1:0] capacity;
  ram_req_t         ram_req;
  pair_t            ram_rdata;
  logic             res_valid;
  logic             res_taken;
  rsp_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  bkv_pair_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );

  bkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .capacity  (capacity),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res)
  );

  assign res_taken = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_taken) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      rsp <= res;
    end
  end

endmodule

@@ rtl/bkv_checker.sv @@
// ----------------------------------------------------------------------------
// bkv_checker
// Port-level checks of the bounded key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bkv_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bkv_pkg::rsp_t rsp
);
  import bkv_pkg::*;

  `CHK_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
  `CHK_NEXT(a_one_in_flight, clk, rst, req_valid && !req_stall, req_stall, "second request taken while busy")
  `CHK_ALWAYS(a_empty_flag, clk, rst, !rsp_valid || (rsp.is_empty == (rsp.entry_count == '0)), "empty flag disagrees with count")
  `CHK_ALWAYS(a_count_bound, clk, rst, !rsp_valid || (rsp.entry_count <= ENTRY_W'(DEPTH)), "count above depth")
  `CHK_ALWAYS(a_fail_zero, clk, rst, !rsp_valid || rsp.ok || (rsp.out_key == '0 && rsp.out_value == '0), "failed response carries data")

endmodule

bind bounded_key_value_table bkv_checker u_bkv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded key/value table. A scoreboard class
// keeps its own copy of the pairs, the count and the capacity, predicts one
// response per accepted request and checks each response in order. Directed
// requests cover the corner cases; random phases at several capacities use
// a small key pool so that hits, full tables and compaction happen often.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bkv_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
  localparam int POOL_SIZE   = 24;
  localparam int SETTLE      = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES = 400;

  class kv_table_model;
    logic [KEY_WIDTH-1:0]   keys [DEPTH];
    logic [VALUE_WIDTH-1:0] values [DEPTH];
    int unsigned            count;
    logic [CAP_W-1:0]       cap;
    rsp_t                   pending_rsp[$];
    int unsigned            errors;

    function new();
      count  = 0;
      cap    = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap = c;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    function int find_key(logic [KEY_WIDTH-1:0] k);
      for (int i = 0; i < count; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function bit try_insert(logic [KEY_WIDTH-1:0] k, logic [VALUE_WIDTH-1:0] v);
      int unsigned limit;
      limit = (cap < DEPTH) ? cap : DEPTH;
      if (count >= limit) return 1'b0;
      if (find_key(k) >= 0) return 1'b0;
      keys[count]   = k;
      values[count] = v;
      count++;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   pos;
      e   = '0;
      pos = -1;
      case (r.opcode)
        OP_INSERT: begin
          e.ok = try_insert(r.req_key, r.req_value);
        end
        OP_UPDATE, OP_UPSERT: begin
          pos = find_key(r.req_key);
          if (pos >= 0) begin
            values[pos] = r.req_value;
            e.ok = 1'b1;
          end else if (r.opcode == OP_UPSERT) begin
            e.ok = try_insert(r.req_key, r.req_value);
          end
        end
        OP_ERASE: begin
          pos = find_key(r.req_key);
          if (pos >= 0) begin
            for (int j = pos; j + 1 < count; j++) begin
              keys[j]   = keys[j + 1];
              values[j] = values[j + 1];
            end
            count--;
            e.ok = 1'b1;
          end
        end
        OP_LOOKUP: begin
          pos = find_key(r.req_key);
          if (pos >= 0) begin
            e.out_value = values[pos];
            e.ok = 1'b1;
          end
        end
        OP_READ_AT: begin
          if (r.req_index < count) begin
            e.out_key   = keys[r.req_index];
            e.out_value = values[r.req_index];
            e.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      e.entry_count = ENTRY_W'(count);
      e.is_empty    = (count == 0);
      pending_rsp.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        report("response with no pending request");
      end else begin
        e = pending_rsp.pop_front();
        if (got.ok !== e.ok)
          report($sformatf("ok got %0b exp %0b", got.ok, e.ok));
        if (got.out_key !== e.out_key)
          report($sformatf("out_key got %h exp %h", got.out_key, e.out_key));
        if (got.out_value !== e.out_value)
          report($sformatf("out_value got %h exp %h", got.out_value, e.out_value));
        if (got.entry_count !== e.entry_count)
          report($sformatf("entry_count got %0d exp %0d", got.entry_count, e.entry_count));
        if (got.is_empty !== e.is_empty)
          report($sformatf("is_empty got %0b exp %0b", got.is_empty, e.is_empty));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             rsp_hold = 1'b0;

  int               send_idle = 0;
  int               stall_pct = 0;
  logic [DATA_W-1:0] key_pool [POOL_SIZE];
  kv_table_model    sb;

  bounded_key_value_table uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    rsp_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
      @(posedge clk);
    end
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] k,
                                    logic [DATA_W-1:0] v, logic [IDX_W-1:0] idx);
    req_t r;
    r.opcode    = op;
    r.req_key   = k;
    r.req_value = v;
    r.req_index = idx;
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [DATA_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 25)      op = OP_INSERT;
    else if (pick < 35) op = OP_UPDATE;
    else if (pick < 50) op = OP_UPSERT;
    else if (pick < 68) op = OP_ERASE;
    else if (pick < 82) op = OP_LOOKUP;
    else if (pick < 96) op = OP_READ_AT;
    else op = ($urandom_range(1) == 0) ? OP_UNDEF_LO : OP_UNDEF_HI;
    if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
    else k = $urandom;
    return make_req(op, k, $urandom, IDX_W'($urandom_range(DEPTH - 1)));
  endfunction

  task automatic send(input req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_capacity(c);
  endtask

  task automatic hold_receiver(input int cycles);
    rsp_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rsp_hold <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] c, input int s_idle, input int r_stall,
                           input int n, input bit hold, input bit pause);
    set_capacity(c);
    send_idle = s_idle;
    stall_pct = r_stall;
    if (hold) begin
      fork
        hold_receiver(HOLD_CYCLES);
      join_none
    end
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2) wait_drained();
      send(random_req());
    end
  endtask

  initial begin
    sb          = new();
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req         <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_capacity(CAP_W'(16));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd0));
    send(make_req(OP_LOOKUP, 32'h1234_5678, 32'h0, 4'd0));
    send(make_req(OP_UPDATE, 32'h1234_5678, 32'h1, 4'd0));
    send(make_req(OP_ERASE, 32'h1234_5678, 32'h0, 4'd0));
    send(make_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 4'd0));
    send(make_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 4'd0));
    send(make_req(OP_INSERT, 32'h0, 32'h1, 4'd0));
    send(make_req(OP_UPSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'd0));
    send(make_req(OP_UPSERT, 32'h5, 32'h5A5A_5A5A, 4'd0));
    send(make_req(OP_UPDATE, 32'h0, 32'h8000_0001, 4'd0));
    send(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd0));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd2));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd3));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd15));
    send(make_req(OP_ERASE, 32'h0, 32'h0, 4'd0));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd0));
    send(make_req(OP_READ_AT, 32'h0, 32'h0, 4'd1));
    send(make_req(OP_UNDEF_LO, $urandom, $urandom, 4'd0));
    send(make_req(OP_UNDEF_HI, $urandom, $urandom, 4'd1));
    set_capacity(CAP_W'(2));
    send(make_req(OP_INSERT, 32'h9, 32'h9, 4'd0));
    send(make_req(OP_UPSERT, 32'h9, 32'h9, 4'd0));
    set_capacity(CAP_W'(1));
    send(make_req(OP_INSERT, 32'hA, 32'hA, 4'd0));
    send(make_req(OP_UPDATE, 32'h5, 32'h1357_9BDF, 4'd0));
    send(make_req(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 4'd0));
    send(make_req(OP_INSERT, 32'hB, 32'hB, 4'd0));

    run_phase(CAP_W'(16), 0, 0, 200, 1'b0, 1'b0);
    run_phase(CAP_W'(0), 77, 0, 100, 1'b0, 1'b0);
    run_phase(CAP_W'(31), 0, 77, 250, 1'b0, 1'b0);
    run_phase(CAP_W'(4), 36, 36, 200, 1'b0, 1'b1);
    run_phase(CAP_W'(1), 0, 0, 150, 1'b0, 1'b0);
    run_phase(CAP_W'(16), 77, 77, 200, 1'b0, 1'b0);
    run_phase(CAP_W'(8), 0, 0, 200, 1'b1, 1'b0);
    run_phase(CAP_W'(12), 36, 36, 200, 1'b0, 1'b0);
    run_phase(CAP_W'(16), 0, 77, 200, 1'b0, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
